/* rtl/core/cnv_pkg.sv */
// ----------------------------------------------------------------------------
// cnv_pkg
// Shared constants and types for the zero-padded 2D convolution core.
// ----------------------------------------------------------------------------
`default_nettype none

package cnv_pkg;

  localparam int RADIUS     = 8;
  localparam int KSIDE      = 2 * RADIUS + 1;
  localparam int KTAPS      = KSIDE * KSIDE;
  localparam int SLOTS      = 2 * RADIUS + 2;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int DIM_W   = 11;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LDEPTH  = SLOTS * MAX_WIDTH;
  localparam int KADDR_W = $clog2(KTAPS);
  localparam int KX_W    = $clog2(KSIDE + 1);
  localparam int WAIT_W  = $clog2(KSIDE + 2);
  localparam int POS_W   = 12;

  localparam int PIX_W  = 16;
  localparam int COEF_W = 16;
  localparam int PROD_W = PIX_W + COEF_W + 1;
  localparam int PSUM_W = PROD_W + 5;
  localparam int SUM_W  = 48;

  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic        [PIX_W-1:0]  pix;
  } tap_t;

endpackage

`default_nettype wire

/* rtl/core/cnv_ram.sv */
// ----------------------------------------------------------------------------
// cnv_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module cnv_ram #(
  parameter int DATA_W = 16,
  parameter int DEPTH  = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/core/cnv_cell.sv */
// ----------------------------------------------------------------------------
// cnv_cell
// One tap of the row chain: holds a coefficient/pixel pair passed along by
// its neighbor, multiplies it and adds the product to the running sum.
// ----------------------------------------------------------------------------
`default_nettype none

module cnv_cell (
  input  wire logic                              clk,
  input  wire logic                              shift_en,
  input  wire cnv_pkg::tap_t                     tap_in,
  input  wire logic signed [cnv_pkg::PSUM_W-1:0] psum_in,
  output cnv_pkg::tap_t                          tap_out,
  output logic signed [cnv_pkg::PSUM_W-1:0]      psum_out
);

  cnv_pkg::tap_t                      tap_r;
  logic signed [cnv_pkg::PROD_W-1:0]  prod_r;
  logic signed [cnv_pkg::PSUM_W-1:0]  psum_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      tap_r <= tap_in;
    end
    prod_r <= $signed({1'b0, tap_r.pix}) * tap_r.coef;
    psum_r <= psum_in + {{(cnv_pkg::PSUM_W - cnv_pkg::PROD_W){prod_r[cnv_pkg::PROD_W-1]}},
                         prod_r};
  end

  assign tap_out  = tap_r;
  assign psum_out = psum_r;

endmodule

`default_nettype wire

/* rtl/core/conv2d_zero_pad_window_core.sv */
// ----------------------------------------------------------------------------
// conv2d_zero_pad_window_core
// Streaming 17x17 convolution with zero padding, row chain of MAC cells.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tuser=kind, tdata=index,coef,pixel
//  out_     out  out_tvalid/tready    tdata=col,row,sum, tlast=last
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Load words are taken in ST_IDLE; pixel/flush words pass ST_CHECK, which
//  returns to ST_IDLE when no result is ready. Kernel rows outside the
//  image are skipped; each row inside it is read, drained and summed, paced
//  by the single read port of the line and kernel memories (17 reads per
//  row) and the 17-cell sum chain. rst_n is synchronous; line memory needs
//  no clearing. Register writes are taken only when idle and hold off
//  input words. A waiting result blocks only the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module conv2d_zero_pad_window_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // coef_index[8:0], coef_value[24:9], pixel[40:25]
  input  wire logic [1:0]  in_tuser,   // kind[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // out_col[9:0], out_row[19:10], sum[67:20]
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [cnv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cnv_pkg::DIM_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_ROW, ST_FILL, ST_DRAIN, ST_NEXT, ST_DONE
  } state_t;

  localparam int LADDR_W = $clog2(cnv_pkg::LDEPTH);

  state_t                         state_r;
  logic [cnv_pkg::DIM_W-1:0]      width_r, height_r;
  logic [cnv_pkg::COL_W-1:0]      in_col_r, emit_col_r;
  logic [cnv_pkg::ROW_W-1:0]      in_row_r, emit_row_r;
  logic [cnv_pkg::SLOT_W-1:0]     in_slot_r, emit_slot_r, row_slot_r;
  logic                           in_done_r;
  logic [cnv_pkg::KX_W-1:0]       ky_r, kx_r;
  logic [cnv_pkg::KADDR_W-1:0]    krow_r;
  logic [cnv_pkg::WAIT_W-1:0]     wait_r;
  logic signed [cnv_pkg::SUM_W-1:0] acc_r;
  logic                           rd_vld_r, pad_r;
  logic                           out_vld_r, olast_r;
  logic [cnv_pkg::COL_W-1:0]      ocol_r;
  logic [cnv_pkg::ROW_W-1:0]      orow_r;
  logic [cnv_pkg::SUM_W-1:0]      osum_r;

  logic                           in_acc, kram_we, lram_we, issue;
  logic [cnv_pkg::KIND_W-1:0]     kind;
  logic [cnv_pkg::KADDR_W-1:0]    kidx;
  logic [cnv_pkg::COEF_W-1:0]     kram_rdata;
  logic [cnv_pkg::PIX_W-1:0]      lram_rdata;
  logic [cnv_pkg::DIM_W-1:0]      nr, nc, er_ext, ec_ext, dim_clamp;
  logic                           out_ready, row_ok, col_ok, last_px;
  logic signed [cnv_pkg::POS_W-1:0] rr, cc;
  logic [cnv_pkg::SLOT_W:0]       start_sum;
  logic [cnv_pkg::SLOT_W-1:0]     start_slot;

  cnv_pkg::tap_t                          taps  [cnv_pkg::KSIDE];
  logic signed [cnv_pkg::PSUM_W-1:0]      psums [cnv_pkg::KSIDE+1];

  assign in_tready = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign kind      = in_tuser;
  assign kidx      = in_tdata[8:0];
  assign kram_we   = in_acc && (kind == cnv_pkg::KIND_LOAD) &&
                     ({1'b0, kidx} < 10'(cnv_pkg::KTAPS));
  assign lram_we   = in_acc && (kind == cnv_pkg::KIND_PIXEL) && !in_done_r;
  assign issue     = (state_r == ST_FILL) && (kx_r < cnv_pkg::KX_W'(cnv_pkg::KSIDE));

  always_comb begin
    er_ext    = {1'b0, emit_row_r} + cnv_pkg::DIM_W'(cnv_pkg::RADIUS);
    ec_ext    = {1'b0, emit_col_r} + cnv_pkg::DIM_W'(cnv_pkg::RADIUS);
    nr        = (er_ext > height_r - 1'b1) ? height_r - 1'b1 : er_ext;
    nc        = (ec_ext > width_r - 1'b1) ? width_r - 1'b1 : ec_ext;
    out_ready = in_done_r || ({1'b0, in_row_r} > nr) ||
                (({1'b0, in_row_r} == nr) && ({1'b0, in_col_r} > nc));
    rr     = $signed({2'b0, emit_row_r}) + $signed({7'b0, ky_r}) -
             cnv_pkg::POS_W'(cnv_pkg::RADIUS);
    cc     = $signed({2'b0, emit_col_r}) + $signed({7'b0, kx_r}) -
             cnv_pkg::POS_W'(cnv_pkg::RADIUS);
    row_ok = !rr[cnv_pkg::POS_W-1] && (rr[cnv_pkg::DIM_W-1:0] < height_r);
    col_ok = !cc[cnv_pkg::POS_W-1] && (cc[cnv_pkg::DIM_W-1:0] < width_r);
    last_px = ({1'b0, emit_row_r} == height_r - 1'b1) &&
              ({1'b0, emit_col_r} == width_r - 1'b1);
    start_sum  = {1'b0, emit_slot_r} +
                 (cnv_pkg::SLOT_W+1)'(cnv_pkg::SLOTS - cnv_pkg::RADIUS);
    start_slot = (start_sum >= (cnv_pkg::SLOT_W+1)'(cnv_pkg::SLOTS)) ?
                 cnv_pkg::SLOT_W'(start_sum - (cnv_pkg::SLOT_W+1)'(cnv_pkg::SLOTS)) :
                 start_sum[cnv_pkg::SLOT_W-1:0];
    if (cfg_data == '0) begin
      dim_clamp = cnv_pkg::DIM_W'(1);
    end else if (cfg_index == cnv_pkg::REG_WIDTH &&
                 cfg_data > cnv_pkg::DIM_W'(cnv_pkg::MAX_WIDTH)) begin
      dim_clamp = cnv_pkg::DIM_W'(cnv_pkg::MAX_WIDTH);
    end else if (cfg_data > cnv_pkg::DIM_W'(cnv_pkg::MAX_HEIGHT)) begin
      dim_clamp = cnv_pkg::DIM_W'(cnv_pkg::MAX_HEIGHT);
    end else begin
      dim_clamp = cfg_data;
    end
  end

  cnv_ram #(.DATA_W(cnv_pkg::COEF_W), .DEPTH(cnv_pkg::KTAPS)) u_kram (
    .clk   (clk),
    .we    (kram_we),
    .waddr (kidx),
    .wdata (in_tdata[24:9]),
    .raddr (krow_r + cnv_pkg::KADDR_W'(kx_r)),
    .rdata (kram_rdata)
  );

  cnv_ram #(.DATA_W(cnv_pkg::PIX_W), .DEPTH(cnv_pkg::LDEPTH)) u_lram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (LADDR_W'({in_slot_r, in_col_r})),
    .wdata (in_tdata[40:25]),
    .raddr (LADDR_W'({row_slot_r, cc[cnv_pkg::COL_W-1:0]})),
    .rdata (lram_rdata)
  );

  assign taps[0].coef = pad_r ? '0 : $signed(kram_rdata);
  assign taps[0].pix  = pad_r ? '0 : lram_rdata;
  assign psums[0]     = '0;

  for (genvar k = 0; k < cnv_pkg::KSIDE; k++) begin : g_cell
    if (k < cnv_pkg::KSIDE - 1) begin : g_mid
      cnv_cell u_cell (
        .clk      (clk),
        .shift_en (rd_vld_r),
        .tap_in   (taps[k]),
        .psum_in  (psums[k]),
        .tap_out  (taps[k+1]),
        .psum_out (psums[k+1])
      );
    end else begin : g_end
      cnv_cell u_cell (
        .clk      (clk),
        .shift_en (rd_vld_r),
        .tap_in   (taps[k]),
        .psum_in  (psums[k]),
        .tap_out  (),
        .psum_out (psums[k+1])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= cnv_pkg::DIM_W'(cnv_pkg::MAX_WIDTH);
      height_r    <= cnv_pkg::DIM_W'(cnv_pkg::MAX_HEIGHT);
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_slot_r   <= '0;
      emit_col_r  <= '0;
      emit_row_r  <= '0;
      emit_slot_r <= '0;
      in_done_r   <= 1'b0;
      out_vld_r   <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      pad_r    <= !col_ok;
      if (out_vld_r && out_tready && state_r != ST_DONE) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready && (cfg_index == cnv_pkg::REG_WIDTH ||
                                     cfg_index == cnv_pkg::REG_HEIGHT)) begin
        if (cfg_index == cnv_pkg::REG_WIDTH) begin
          width_r <= dim_clamp;
        end else begin
          height_r <= dim_clamp;
        end
        in_col_r    <= '0;
        in_row_r    <= '0;
        in_slot_r   <= '0;
        emit_col_r  <= '0;
        emit_row_r  <= '0;
        emit_slot_r <= '0;
        in_done_r   <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && kind == cnv_pkg::KIND_PIXEL) begin
            if (!in_done_r) begin
              if ({1'b0, in_col_r} + 1'b1 >= width_r) begin
                in_col_r  <= '0;
                in_row_r  <= in_row_r + 1'b1;
                in_slot_r <= (in_slot_r == cnv_pkg::SLOT_W'(cnv_pkg::SLOTS - 1)) ?
                             '0 : in_slot_r + 1'b1;
                if ({1'b0, in_row_r} + 1'b1 >= height_r) begin
                  in_done_r <= 1'b1;
                end
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
            state_r <= ST_CHECK;
          end else if (in_acc && kind == cnv_pkg::KIND_FLUSH) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (out_ready) begin
            ky_r       <= '0;
            krow_r     <= '0;
            acc_r      <= '0;
            row_slot_r <= start_slot;
            state_r    <= ST_ROW;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_ROW: begin
          if (row_ok) begin
            kx_r    <= '0;
            state_r <= ST_FILL;
          end else if (ky_r == cnv_pkg::KX_W'(cnv_pkg::KSIDE - 1)) begin
            state_r <= ST_DONE;
          end else begin
            ky_r       <= ky_r + 1'b1;
            krow_r     <= krow_r + cnv_pkg::KADDR_W'(cnv_pkg::KSIDE);
            row_slot_r <= (row_slot_r == cnv_pkg::SLOT_W'(cnv_pkg::SLOTS - 1)) ?
                          '0 : row_slot_r + 1'b1;
          end
        end
        ST_FILL: begin
          if (issue) begin
            kx_r <= kx_r + 1'b1;
          end else begin
            wait_r  <= '0;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          wait_r <= wait_r + 1'b1;
          if (wait_r == cnv_pkg::WAIT_W'(cnv_pkg::KSIDE + 1)) begin
            state_r <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          acc_r <= acc_r +
                   {{(cnv_pkg::SUM_W - cnv_pkg::PSUM_W){psums[cnv_pkg::KSIDE][cnv_pkg::PSUM_W-1]}},
                    psums[cnv_pkg::KSIDE]};
          if (ky_r == cnv_pkg::KX_W'(cnv_pkg::KSIDE - 1)) begin
            state_r <= ST_DONE;
          end else begin
            ky_r       <= ky_r + 1'b1;
            krow_r     <= krow_r + cnv_pkg::KADDR_W'(cnv_pkg::KSIDE);
            row_slot_r <= (row_slot_r == cnv_pkg::SLOT_W'(cnv_pkg::SLOTS - 1)) ?
                          '0 : row_slot_r + 1'b1;
            state_r    <= ST_ROW;
          end
        end
        ST_DONE: begin
          if (!out_vld_r || out_tready) begin
            out_vld_r <= 1'b1;
            ocol_r    <= emit_col_r;
            orow_r    <= emit_row_r;
            osum_r    <= acc_r;
            olast_r   <= last_px;
            if (last_px) begin
              in_col_r    <= '0;
              in_row_r    <= '0;
              in_slot_r   <= '0;
              emit_col_r  <= '0;
              emit_row_r  <= '0;
              emit_slot_r <= '0;
              in_done_r   <= 1'b0;
            end else if ({1'b0, emit_col_r} + 1'b1 >= width_r) begin
              emit_col_r  <= '0;
              emit_row_r  <= emit_row_r + 1'b1;
              emit_slot_r <= (emit_slot_r == cnv_pkg::SLOT_W'(cnv_pkg::SLOTS - 1)) ?
                             '0 : emit_slot_r + 1'b1;
            end else begin
              emit_col_r <= emit_col_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0, osum_r, orow_r, ocol_r};
  assign out_tlast  = olast_r;

  a_one_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(kram_we && lram_we))
    else $error("kernel and line memories written in one cycle");

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the done state");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (kx_r <= cnv_pkg::KX_W'(cnv_pkg::KSIDE)))
    else $error("fill counter past the kernel width");

  a_read_from_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r == ST_FILL))
    else $error("read data marked valid outside a fill");

endmodule

`default_nettype wire

/* tb/conv2d_zero_pad_window_core_tb.sv */
// ----------------------------------------------------------------------------
// conv2d_zero_pad_window_core_tb
// Self-checking bench for the streaming zero-padded 17x17 convolution core.
// Words go in through the input stream while a behavioral copy of the core
// predicts each output pixel. The output stream is checked in order.
// Directed tests cover the kernel load, register clamping, wide and tall
// frames and overrun pixels. Random frames of small size follow, with
// bursts of idle cycles on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module conv2d_zero_pad_window_core_tb;

  localparam int SETTLE   = 700;
  localparam int WDOG_MAX = 5000;
  localparam int N_WORDS  = 1400;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [9:0]         col;
    logic [9:0]         row;
    logic signed [47:0] sum;
    logic               last;
  } pix_out_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [cnv_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [cnv_pkg::DIM_W-1:0]     cfg_data;

  conv2d_zero_pad_window_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow copy of the core
  logic [15:0] kern_mem [cnv_pkg::KTAPS];
  logic [15:0] line_mem [cnv_pkg::SLOTS*cnv_pkg::MAX_WIDTH];
  int unsigned img_w, img_h, wr_col, wr_row, rd_col, rd_row;
  bit          frame_in_done;

  pix_out_t    pending_pix [$];
  int          errors = 0;
  int          sent_words = 0;
  bit          calm = 1'b0;

  function automatic void frame_restart();
    wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0; frame_in_done = 0;
  endfunction

  function automatic int unsigned clamp_dim(logic [cnv_pkg::DIM_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit window_ready();
    int unsigned nr, nc;
    if (frame_in_done) return 1;
    nr = rd_row + cnv_pkg::RADIUS;
    if (nr > img_h - 1) nr = img_h - 1;
    nc = rd_col + cnv_pkg::RADIUS;
    if (nc > img_w - 1) nc = img_w - 1;
    return wr_row > nr || (wr_row == nr && wr_col > nc);
  endfunction

  function automatic void emit_pixel();
    longint acc;
    int rr, cc;
    pix_out_t p;
    acc = 0;
    for (int ky = 0; ky < cnv_pkg::KSIDE; ky++) begin
      rr = int'(rd_row) + ky - cnv_pkg::RADIUS;
      if (rr < 0 || rr >= int'(img_h)) continue;
      for (int kx = 0; kx < cnv_pkg::KSIDE; kx++) begin
        cc = int'(rd_col) + kx - cnv_pkg::RADIUS;
        if (cc < 0 || cc >= int'(img_w)) continue;
        acc += longint'($signed(kern_mem[ky*cnv_pkg::KSIDE+kx])) *
               longint'({1'b0, line_mem[(rr % cnv_pkg::SLOTS)*cnv_pkg::MAX_WIDTH + cc]});
      end
    end
    p.col  = rd_col[9:0];
    p.row  = rd_row[9:0];
    p.sum  = acc[47:0];
    p.last = (rd_row == img_h - 1) && (rd_col == img_w - 1);
    pending_pix.push_back(p);
    if (p.last) frame_restart();
    else begin
      rd_col++;
      if (rd_col >= img_w) begin
        rd_col = 0;
        rd_row++;
      end
    end
  endfunction

  function automatic void predict_word(logic [1:0] kind, logic [8:0] idx,
                                       logic [15:0] coef, logic [15:0] pix);
    if (kind == cnv_pkg::KIND_LOAD) begin
      if (idx < cnv_pkg::KTAPS) kern_mem[idx] = coef;
      return;
    end
    if (kind == cnv_pkg::KIND_PIXEL) begin
      if (!frame_in_done) begin
        line_mem[(wr_row % cnv_pkg::SLOTS)*cnv_pkg::MAX_WIDTH + wr_col] = pix;
        wr_col++;
        if (wr_col >= img_w) begin
          wr_col = 0;
          wr_row++;
          if (wr_row >= img_h) frame_in_done = 1;
        end
      end
    end else if (kind != cnv_pkg::KIND_FLUSH) begin
      return;
    end
    if (window_ready()) emit_pixel();
  endfunction

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_word(logic [1:0] kind, logic [8:0] idx, logic [15:0] coef,
                           logic [15:0] pix);
    idle_gap();
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'd0, pix, coef, idx};
    do @(posedge clk); while (!in_tready);
    sent_words++;
    predict_word(kind, idx, coef, pix);
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    while (pending_pix.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [cnv_pkg::CFG_IDX_W-1:0] idx,
                           logic [cnv_pkg::DIM_W-1:0] val);
    drain_wait();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cnv_pkg::REG_WIDTH) img_w = clamp_dim(val, cnv_pkg::MAX_WIDTH);
    else img_h = clamp_dim(val, cnv_pkg::MAX_HEIGHT);
    frame_restart();
  endtask

  task automatic send_pixels(int n);
    for (int i = 0; i < n; i++)
      send_word(cnv_pkg::KIND_PIXEL, 9'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // completes a partly sent frame with pixels, then drains it with flushes
  task automatic flush_frame();
    while (wr_row != 0 || wr_col != 0 || rd_row != 0 || rd_col != 0 || frame_in_done) begin
      if (frame_in_done)
        send_word(cnv_pkg::KIND_FLUSH, 9'($urandom), 16'($urandom), 16'($urandom));
      else
        send_word(cnv_pkg::KIND_PIXEL, 9'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_kernel_load();
    for (int i = 0; i < cnv_pkg::KTAPS; i++)
      send_word(cnv_pkg::KIND_LOAD, 9'(i), 16'($urandom), 16'($urandom));
    send_word(cnv_pkg::KIND_LOAD, 9'd0, 16'h8000, 16'h0000);
    send_word(cnv_pkg::KIND_LOAD, 9'(cnv_pkg::KTAPS-1), 16'h7fff, 16'hffff);
    send_word(cnv_pkg::KIND_LOAD, 9'(cnv_pkg::KTAPS), 16'h1234, 16'h0);
    send_word(cnv_pkg::KIND_LOAD, 9'h1ff, 16'hffff, 16'h0);
    send_word(KIND_SPARE, 9'h1ff, 16'hffff, 16'hffff);
  endtask

  task automatic test_reg_clamp();
    write_reg(cnv_pkg::REG_WIDTH, '0);
    write_reg(cnv_pkg::REG_HEIGHT, '0);
    send_word(cnv_pkg::KIND_FLUSH, 9'd0, 16'd0, 16'd0);
    send_word(cnv_pkg::KIND_PIXEL, 9'd0, 16'd0, 16'hffff);
    send_word(cnv_pkg::KIND_PIXEL, 9'd0, 16'd0, 16'h0000);
    send_word(cnv_pkg::KIND_PIXEL, 9'd0, 16'd0, 16'hffff);
  endtask

  task automatic test_wide_row();
    write_reg(cnv_pkg::REG_WIDTH, 11'h7ff);
    write_reg(cnv_pkg::REG_HEIGHT, 11'd1);
    send_pixels(40);
  endtask

  task automatic test_tall_col();
    write_reg(cnv_pkg::REG_WIDTH, 11'd1);
    write_reg(cnv_pkg::REG_HEIGHT, 11'h7ff);
    send_pixels(30);
  endtask

  task automatic test_overrun();
    write_reg(cnv_pkg::REG_WIDTH, 11'd3);
    write_reg(cnv_pkg::REG_HEIGHT, 11'd2);
    send_word(cnv_pkg::KIND_FLUSH, 9'd0, 16'd0, 16'd0);
    send_pixels(8);
    flush_frame();
  endtask

  task automatic test_random_frames();
    int phase;
    int w, h;
    phase = 0;
    while (sent_words < N_WORDS) begin
      if (sent_words > N_WORDS - 150) calm = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        w = $urandom_range(1, 40); h = $urandom_range(1, 3);
      end else begin
        w = $urandom_range(1, 16); h = $urandom_range(1, 5);
      end
      if (w != img_w || $urandom_range(0, 1)) write_reg(cnv_pkg::REG_WIDTH, 11'(w));
      if (h != img_h || $urandom_range(0, 1)) write_reg(cnv_pkg::REG_HEIGHT, 11'(h));
      repeat ($urandom_range(0, 3)) begin
        send_word(cnv_pkg::KIND_LOAD, 9'($urandom), 16'($urandom), 16'($urandom));
      end
      for (int i = 0; i < w*h; i++) begin
        case ($urandom_range(0, 15))
          0: send_word(KIND_SPARE, 9'($urandom), 16'($urandom), 16'($urandom));
          1: send_word(cnv_pkg::KIND_FLUSH, 9'($urandom), 16'($urandom), 16'($urandom));
          default: ;
        endcase
        send_word(cnv_pkg::KIND_PIXEL, 9'($urandom), 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 3) == 0) send_pixels($urandom_range(1, 3));
      if (phase == 3) drain_wait();
      flush_frame();
      phase++;
    end
  endtask

  // output stream back-pressure
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pix.size() == 0) begin
        $display("%0t: unexpected word col=%0d row=%0d", $time, out_tdata[9:0], out_tdata[19:10]);
        errors++;
      end else begin
        want = pending_pix.pop_front();
        if (out_tdata[9:0] !== want.col) begin
          $display("%0t: col exp %0d got %0d", $time, want.col, out_tdata[9:0]);
          errors++;
        end
        if (out_tdata[19:10] !== want.row) begin
          $display("%0t: row exp %0d got %0d", $time, want.row, out_tdata[19:10]);
          errors++;
        end
        if (out_tdata[67:20] !== want.sum) begin
          $display("%0t: sum exp %0d got %0d", $time, want.sum, $signed(out_tdata[67:20]));
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last exp %0b got %0b", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    img_w = cnv_pkg::MAX_WIDTH;
    img_h = cnv_pkg::MAX_HEIGHT;
    frame_restart();
    for (int i = 0; i < cnv_pkg::KTAPS; i++) kern_mem[i] = '0;
    for (int i = 0; i < cnv_pkg::SLOTS*cnv_pkg::MAX_WIDTH; i++) line_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_kernel_load();
    test_reg_clamp();
    test_wide_row();
    test_tall_col();
    test_overrun();
    test_random_frames();
    drain_wait();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/cnv_pkg.sv
rtl/core/cnv_ram.sv
rtl/core/cnv_cell.sv
rtl/core/conv2d_zero_pad_window_core.sv
tb/conv2d_zero_pad_window_core_tb.sv
